// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, codes and helpers for the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int FREE_DEPTH_DEF = 256;

  localparam int IDX_W   = 32;
  localparam int GEN_W   = 28;
  localparam int FLG_W   = 4;
  localparam int HANDLE_W = 64;
  localparam int STORE_W = IDX_W + GEN_W;

  localparam logic REQ_CREATE  = 1'b0;
  localparam logic REQ_DESTROY = 1'b1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EXHAUST = 2'd2;

  typedef struct packed {
    logic                req_type;
    logic [FLG_W-1:0]    new_flags;
    logic [HANDLE_W-1:0] freed_handle;
  } gha_in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
  } gha_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } gha_state_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_POP,
    SEL_FRESH
  } gha_sel_t;

  typedef struct packed {
    logic       capture;
    logic       push;
    logic       pop_rd;
    logic       fresh_take;
    logic       out_load;
    gha_sel_t   out_sel;
    logic [1:0] out_status;
  } gha_cmd_t;

  typedef struct packed {
    logic req_destroy;
    logic empty;
    logic full;
    logic exhausted;
    logic out_free;
  } gha_sts_t;

  // bump generation (wraps) and replace the flags
  function automatic logic [HANDLE_W-1:0] bump_and_flag(
    input logic [STORE_W-1:0] h,
    input logic [FLG_W-1:0]   f
  );
    logic [GEN_W-1:0] gen;
    gen = h[STORE_W-1:IDX_W] + GEN_W'(1);
    return {f, gen, h[IDX_W-1:0]};
  endfunction

endpackage

// ----- rtl/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Request sequencer: captures a request, then steps the datapath through it.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gha_pkg::gha_sts_t sts,
  output gha_pkg::gha_cmd_t cmd
);

  gha_pkg::gha_state_t state_r;
  gha_pkg::gha_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.out_sel    = gha_pkg::SEL_ZERO;
    cmd.out_status = gha_pkg::STAT_OK;
    case (state_r)
      gha_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = gha_pkg::ST_EXEC;
        end
      end
      gha_pkg::ST_EXEC: begin
        if (sts.req_destroy) begin
          if (sts.out_free) begin
            cmd.push       = !sts.full;
            cmd.out_load   = 1'b1;
            cmd.out_sel    = gha_pkg::SEL_ZERO;
            cmd.out_status = sts.full ? gha_pkg::STAT_FULL : gha_pkg::STAT_OK;
            state_nxt      = gha_pkg::ST_IDLE;
          end
        end else if (!sts.empty) begin
          // read the top entry; result formed once data is back
          cmd.pop_rd = 1'b1;
          state_nxt  = gha_pkg::ST_POP;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.exhausted) begin
            cmd.out_sel    = gha_pkg::SEL_ZERO;
            cmd.out_status = gha_pkg::STAT_EXHAUST;
          end else begin
            cmd.fresh_take = 1'b1;
            cmd.out_sel    = gha_pkg::SEL_FRESH;
          end
          state_nxt = gha_pkg::ST_IDLE;
        end
      end
      gha_pkg::ST_POP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = gha_pkg::SEL_POP;
          state_nxt    = gha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/gha_dp.sv -----
// ----------------------------------------------------------------------------
// gha_dp
// Datapath: request register, LIFO free store, fresh-index counter and
// result register.
// ----------------------------------------------------------------------------
module gha_dp #(
  parameter int FREE_DEPTH = gha_pkg::FREE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gha_pkg::gha_in_t  in_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  gha_pkg::gha_cmd_t cmd,
  output gha_pkg::gha_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output gha_pkg::gha_out_t out_data
);

  localparam int AW = $clog2(FREE_DEPTH);
  localparam int CW = $clog2(FREE_DEPTH + 1);

  gha_pkg::gha_in_t                  req_r;
  logic [CW-1:0]                     count_r;
  logic [CW-1:0]                     count_dec;
  logic [gha_pkg::IDX_W:0]           fresh_r;
  logic [gha_pkg::STORE_W-1:0]       mem [FREE_DEPTH];
  logic [gha_pkg::STORE_W-1:0]       rd_q;
  logic                              out_valid_r;
  gha_pkg::gha_out_t                 out_data_r;
  gha_pkg::gha_out_t                 out_nxt;

  assign count_dec = count_r - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  // free store: write at count, registered read at count-1
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[AW-1:0]] <= req_r.freed_handle[gha_pkg::STORE_W-1:0];
    end
    if (cmd.pop_rd) begin
      rd_q <= mem[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.pop_rd) begin
      count_r <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= '0;
    end else if (cfg_we) begin
      fresh_r <= {1'b0, cfg_wdata};
    end else if (cmd.fresh_take) begin
      fresh_r <= fresh_r + (gha_pkg::IDX_W + 1)'(1);
    end
  end

  always_comb begin
    out_nxt.status = cmd.out_status;
    case (cmd.out_sel)
      gha_pkg::SEL_POP: begin
        out_nxt.handle_out = gha_pkg::bump_and_flag(rd_q, req_r.new_flags);
      end
      gha_pkg::SEL_FRESH: begin
        out_nxt.handle_out = gha_pkg::bump_and_flag(
          {{gha_pkg::GEN_W{1'b0}}, fresh_r[gha_pkg::IDX_W-1:0]}, req_r.new_flags);
      end
      default: begin
        out_nxt.handle_out = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.req_destroy = (req_r.req_type == gha_pkg::REQ_DESTROY);
  assign sts.empty       = (count_r == '0);
  assign sts.full        = (count_r == CW'(FREE_DEPTH));
  assign sts.exhausted   = fresh_r[gha_pkg::IDX_W];
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule

// ----- rtl/generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Generational handle allocator with a LIFO free store and fresh-index counter.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns exactly one result beat per request.
// A destroy, or a create served from the fresh-index counter, goes from its
// input beat to its result through the request and output registers; a create
// reusing a freed handle also passes the registered free store read. A new
// request is accepted as soon as the previous one has been placed in the
// output register, even if that result is still stalled. Writing cfg_wdata
// reloads the fresh-index counter; do it only while no request is in flight.
// The free store is not cleared after reset and needs no init time.
module generational_handle_allocator_unit #(
  parameter int FREE_DEPTH = gha_pkg::FREE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gha_pkg::gha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gha_pkg::gha_out_t out_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  gha_pkg::gha_cmd_t cmd;
  gha_pkg::gha_sts_t sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gha_dp #(
    .FREE_DEPTH (FREE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a beat while previous request still in progress");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push into a full free store");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_rd |-> !sts.empty && !sts.req_destroy)
    else $error("pop from empty store or on destroy");

  a_error_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != gha_pkg::STAT_OK |-> out_data.handle_out == '0)
    else $error("error beat carries a nonzero handle");

endmodule
